FILE: hw/rtl/varint_length_prefixed_deframer_assert.svh
// ----------------------------------------------------------------------------
// varint_length_prefixed_deframer_assert
// Assertion macros used by the checker file of the deframer.
// ----------------------------------------------------------------------------
`ifndef VARINT_LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`define VARINT_LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define VLPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define VLPD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/vlpd_pkg.sv
// ----------------------------------------------------------------------------
// vlpd_pkg
// Types and constants of the varint length-prefixed deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package vlpd_pkg;

    localparam int MAX_LENGTH_BYTES_DEF = 5;
    localparam int LEN_W                = 32;
    localparam int DATA_W               = 8;

    typedef enum logic [1:0] {
        PH_NAME_LEN = 2'd0,
        PH_NAME     = 2'd1,
        PH_PAY_LEN  = 2'd2,
        PH_PAY      = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NAME      = 2'd0,
        KIND_PAYLOAD   = 2'd1,
        KIND_ERROR     = 2'd2,
        KIND_EMPTY_END = 2'd3
    } t_kind;

    // One result beat handed from the parser to the output register.
    typedef struct packed {
        logic               vld;
        t_kind              kind;
        logic [DATA_W-1:0]  data;
        logic [LEN_W-1:0]   length;
        logic               last;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/varint_length_prefixed_deframer.sv
// ----------------------------------------------------------------------------
// varint_length_prefixed_deframer
// Splits a byte stream into LEB128 length-prefixed name/payload packets.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | sink      | i_in_valid / o_in_stall | i_in_byte
//  out     | source    | o_out_valid / i_out_stall | o_out_kind, o_out_data,
//          |           |                        | o_field_length, o_packet_last
//
//  One beat per cycle, sustained while the output is not stalled. A byte
//  is held in the input register, is parsed combinationally, and its
//  result (if any) lands in the output register.
//  Reset (synchronous, active low) returns the parser to the name length
//  phase and empties both registers; no clearing pass.
//  A stalled result holds the output register; the input register then holds
//  too and o_in_stall rises while it is occupied.
//  Length bytes make no result except a length error or an empty-payload end.
//
`default_nettype none

module varint_length_prefixed_deframer
    import vlpd_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [DATA_W-1:0] i_in_byte,
    // output channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [1:0]             o_out_kind,
    output logic [DATA_W-1:0]      o_out_data,
    output logic [LEN_W-1:0]       o_field_length,
    output logic                   o_packet_last
);

    // input register
    logic              r_in_vld;
    logic [DATA_W-1:0] r_in_byte;

    logic    out_free;
    logic    step;
    logic    in_acc;
    t_result res;

    // the held byte is parsed as soon as the result register can take its
    // outcome; a byte that makes no result still needs that slot free so the
    // ordering against a stalled beat stays simple
    assign step       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_in_byte;
        end
    end

    vlpd_parser #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    vlpd_out_reg u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_res          (res),
        .o_free         (out_free),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_kind     (o_out_kind),
        .o_out_data     (o_out_data),
        .o_field_length (o_field_length),
        .o_packet_last  (o_packet_last)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/vlpd_parser.sv
// ----------------------------------------------------------------------------
// vlpd_parser
// Packet parse state and the per-byte step: length decode, field counting.
// ----------------------------------------------------------------------------
`default_nettype none

module vlpd_parser
    import vlpd_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [DATA_W-1:0] i_byte,
    output t_result                o_res
);

    localparam int IDX_W = (MAX_LENGTH_BYTES > 1) ? $clog2(MAX_LENGTH_BYTES) : 1;
    // only the first five length bytes can land below bit 32
    localparam int NSLOT = (MAX_LENGTH_BYTES < 5) ? MAX_LENGTH_BYTES : 5;

    t_phase             r_phase, n_phase;
    logic [LEN_W-1:0]   r_acc, n_acc;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [LEN_W-1:0]   r_rem, n_rem;
    logic [LEN_W-1:0]   r_cur, n_cur;

    logic [LEN_W-1:0]   len_merged;
    logic               idx_last;
    logic               more;
    logic [LEN_W-1:0]   rem_dec;

    // length decode: OR in this byte's 7 bits at its slot
    always_comb begin
        len_merged = r_acc;
        for (int k = 0; k < NSLOT; k++) begin
            if (r_idx == IDX_W'(k)) begin
                len_merged = len_merged | (LEN_W'(i_byte[6:0]) << (7 * k));
            end
        end
    end

    assign more     = i_byte[7];
    assign idx_last = (r_idx == IDX_W'(MAX_LENGTH_BYTES - 1));
    assign rem_dec  = (r_rem != '0) ? (r_rem - LEN_W'(1)) : r_rem;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_idx   = r_idx;
        n_rem   = r_rem;
        n_cur   = r_cur;
        if (i_step) begin
            case (r_phase)
                PH_NAME_LEN, PH_PAY_LEN: begin
                    if (more) begin
                        if (idx_last) begin
                            n_phase = PH_NAME_LEN;
                            n_acc   = '0;
                            n_idx   = '0;
                            n_rem   = '0;
                            n_cur   = '0;
                        end else begin
                            n_acc = len_merged;
                            n_idx = r_idx + IDX_W'(1);
                        end
                    end else begin
                        n_acc = '0;
                        n_idx = '0;
                        n_cur = len_merged;
                        n_rem = len_merged;
                        if (r_phase == PH_NAME_LEN) begin
                            n_phase = (len_merged == '0) ? PH_PAY_LEN : PH_NAME;
                        end else begin
                            n_phase = (len_merged == '0) ? PH_NAME_LEN : PH_PAY;
                        end
                    end
                end
                PH_NAME: begin
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = PH_PAY_LEN;
                    end
                end
                PH_PAY: begin
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = PH_NAME_LEN;
                    end
                end
                default: begin
                    n_phase = PH_NAME_LEN;
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_res      = '0;
        o_res.kind = KIND_NAME;
        if (i_step) begin
            case (r_phase)
                PH_NAME_LEN, PH_PAY_LEN: begin
                    if (more && idx_last) begin
                        o_res.vld  = 1'b1;
                        o_res.kind = KIND_ERROR;
                    end else if (!more && (r_phase == PH_PAY_LEN)
                                 && (len_merged == '0)) begin
                        o_res.vld  = 1'b1;
                        o_res.kind = KIND_EMPTY_END;
                        o_res.last = 1'b1;
                    end
                end
                PH_NAME: begin
                    o_res.vld    = 1'b1;
                    o_res.kind   = KIND_NAME;
                    o_res.data   = i_byte;
                    o_res.length = r_cur;
                end
                PH_PAY: begin
                    o_res.vld    = 1'b1;
                    o_res.kind   = KIND_PAYLOAD;
                    o_res.data   = i_byte;
                    o_res.length = r_cur;
                    o_res.last   = (rem_dec == '0);
                end
                default: begin
                    o_res.vld = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NAME_LEN;
            r_acc   <= '0;
            r_idx   <= '0;
            r_rem   <= '0;
            r_cur   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_idx   <= n_idx;
            r_rem   <= n_rem;
            r_cur   <= n_cur;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/vlpd_out_reg.sv
// ----------------------------------------------------------------------------
// vlpd_out_reg
// Result register of the deframer; holds a beat while the sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module vlpd_out_reg
    import vlpd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  t_result                i_res,
    output logic                   o_free,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [1:0]             o_out_kind,
    output logic [DATA_W-1:0]      o_out_data,
    output logic [LEN_W-1:0]       o_field_length,
    output logic                   o_packet_last
);

    logic              r_vld;
    t_kind             r_kind;
    logic [DATA_W-1:0] r_data;
    logic [LEN_W-1:0]  r_len;
    logic              r_last;

    // free when empty or the held beat leaves this cycle
    assign o_free = !r_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res.vld) begin
            r_kind <= i_res.kind;
            r_data <= i_res.data;
            r_len  <= i_res.length;
            r_last <= i_res.last;
        end
    end

    assign o_out_valid    = r_vld;
    assign o_out_kind     = r_kind;
    assign o_out_data     = r_data;
    assign o_field_length = r_len;
    assign o_packet_last  = r_last;

endmodule

`default_nettype wire

FILE: hw/rtl/vlpd_checker.sv
// ----------------------------------------------------------------------------
// vlpd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "varint_length_prefixed_deframer_assert.svh"

module vlpd_checker
    import vlpd_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [1:0]        o_out_kind,
    input wire logic [DATA_W-1:0] o_out_data,
    input wire logic [LEN_W-1:0]  o_field_length,
    input wire logic              o_packet_last
);

    logic err_beat;
    logic end_beat;
    logic name_beat;

    assign err_beat  = o_out_valid && (o_out_kind == KIND_ERROR);
    assign end_beat  = o_out_valid && (o_out_kind == KIND_EMPTY_END);
    assign name_beat = o_out_valid && (o_out_kind == KIND_NAME);

    `VLPD_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_kind) && $stable(o_out_data)
        && $stable(o_field_length) && $stable(o_packet_last),
        "stalled result beat changed")

    `VLPD_ASSERT_IMP(a_err_clean, err_beat,
        (o_out_data == '0) && (o_field_length == '0) && !o_packet_last,
        "length error beat carries data")

    `VLPD_ASSERT_IMP(a_end_last, end_beat,
        o_packet_last && (o_out_data == '0) && (o_field_length == '0),
        "empty-payload end marker malformed")

    `VLPD_ASSERT_IMP(a_name_len, name_beat,
        !o_packet_last && (o_field_length != '0),
        "name byte with zero length or packet end")

endmodule

bind varint_length_prefixed_deframer vlpd_checker u_vlpd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_out_kind     (o_out_kind),
    .o_out_data     (o_out_data),
    .o_field_length (o_field_length),
    .o_packet_last  (o_packet_last)
);

`default_nettype wire

FILE: tb/deframe_tracker_pkg.sv
// ----------------------------------------------------------------------------
// deframe_tracker_pkg
// Predicts the deframer's result beats and checks the ones the block emits.
// ----------------------------------------------------------------------------

package deframe_tracker_pkg;

    import vlpd_pkg::*;

    class deframe_tracker;

        typedef struct {
            t_kind             kind;
            logic [DATA_W-1:0] data;
            logic [LEN_W-1:0]  flen;
            logic              last;
        } t_beat;

        t_phase           phase;
        logic [LEN_W-1:0] acc;
        logic [LEN_W-1:0] remaining;
        logic [LEN_W-1:0] cur_len;
        int unsigned      len_bytes;

        t_beat            pending_beats[$];
        int unsigned      n_bytes;
        int unsigned      n_beats;
        int unsigned      n_fail;
        int unsigned      n_kind[4];

        function new();
            restart();
            n_bytes = 0;
            n_beats = 0;
            n_fail  = 0;
            foreach (n_kind[k]) n_kind[k] = 0;
        endfunction

        function void restart();
            phase     = PH_NAME_LEN;
            acc       = '0;
            remaining = '0;
            cur_len   = '0;
            len_bytes = 0;
        endfunction

        function void push_beat(t_kind kind, logic [DATA_W-1:0] data,
                                logic [LEN_W-1:0] flen, logic last);
            t_beat b;
            b.kind = kind;
            b.data = data;
            b.flen = flen;
            b.last = last;
            pending_beats.push_back(b);
        endfunction

        // One accepted stream byte: advance the parser, queue any result.
        function void take_byte(logic [DATA_W-1:0] b);
            logic [LEN_W-1:0] flen;
            n_bytes++;
            case (phase)
                PH_NAME_LEN, PH_PAY_LEN: begin
                    // bits beyond the 32-bit length are dropped
                    if (len_bytes * 7 < LEN_W)
                        acc |= LEN_W'(b[6:0]) << (len_bytes * 7);
                    if (b[7]) begin
                        len_bytes++;
                        if (len_bytes >= MAX_LENGTH_BYTES_DEF) begin
                            restart();
                            push_beat(KIND_ERROR, '0, '0, 1'b0);
                        end
                    end else begin
                        flen      = acc;
                        acc       = '0;
                        len_bytes = 0;
                        cur_len   = flen;
                        remaining = flen;
                        if (phase == PH_NAME_LEN) begin
                            phase = (flen == 0) ? PH_PAY_LEN : PH_NAME;
                        end else if (flen == 0) begin
                            phase = PH_NAME_LEN;
                            push_beat(KIND_EMPTY_END, '0, '0, 1'b1);
                        end else begin
                            phase = PH_PAY;
                        end
                    end
                end
                PH_NAME: begin
                    push_beat(KIND_NAME, b, cur_len, 1'b0);
                    if (remaining != 0) remaining--;
                    if (remaining == 0) phase = PH_PAY_LEN;
                end
                default: begin
                    if (remaining != 0) remaining--;
                    if (remaining == 0) begin
                        push_beat(KIND_PAYLOAD, b, cur_len, 1'b1);
                        phase = PH_NAME_LEN;
                    end else begin
                        push_beat(KIND_PAYLOAD, b, cur_len, 1'b0);
                    end
                end
            endcase
        endfunction

        // One accepted result beat: compare against the oldest prediction.
        function void match_beat(logic [1:0] kind, logic [DATA_W-1:0] data,
                                 logic [LEN_W-1:0] flen, logic last);
            t_beat want;
            n_beats++;
            if (pending_beats.size() == 0) begin
                $error("unexpected result beat: kind %0d data 0x%02h length %0d",
                       kind, data, flen);
                n_fail++;
                return;
            end
            want = pending_beats.pop_front();
            n_kind[want.kind]++;
            if (kind !== want.kind) begin
                $error("out_kind: expected %0d, actual %0d", want.kind, kind);
                n_fail++;
            end
            if (data !== want.data) begin
                $error("out_data: expected 0x%02h, actual 0x%02h", want.data, data);
                n_fail++;
            end
            if (flen !== want.flen) begin
                $error("field_length: expected %0d, actual %0d", want.flen, flen);
                n_fail++;
            end
            if (last !== want.last) begin
                $error("packet_last: expected %0b, actual %0b", want.last, last);
                n_fail++;
            end
        endfunction

    endclass

endpackage

FILE: tb/varint_length_prefixed_deframer_tb.sv
// ----------------------------------------------------------------------------
// varint_length_prefixed_deframer_tb
// Drives LEB128 length-prefixed packets into the deframer with random gaps
// and output stalls, predicts every result beat, and compares field by field.
// ----------------------------------------------------------------------------

module varint_length_prefixed_deframer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import vlpd_pkg::*;
    import deframe_tracker_pkg::*;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic [DATA_W-1:0] i_in_byte   = '0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [1:0]        o_out_kind;
    logic [DATA_W-1:0] o_out_data;
    logic [LEN_W-1:0]  o_field_length;
    logic              o_packet_last;

    deframe_tracker tracker = new();

    // Idle switches, redrawn per packet so that some stretches run flat out.
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    // Set by the stimulus; the receiver picks it up and holds off that long.
    int unsigned long_hold_req = 0;
    int unsigned n_sent = 0;

    varint_length_prefixed_deframer #(
        .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES_DEF)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_kind    (o_out_kind),
        .o_out_data    (o_out_data),
        .o_field_length(o_field_length),
        .o_packet_last (o_packet_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Input side. Every task returns in the time step of the edge that took
    // its last beat, so valid stays high into the next beat when there is no
    // gap and is only lowered when a gap is actually drawn.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [DATA_W-1:0] b);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        // values read right after the edge are the ones the edge sampled
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        tracker.take_byte(b);
        n_sent++;
    endtask

    // Encodes a length as LEB128. Mostly minimal; sometimes padded with
    // redundant zero groups up to five bytes; sometimes five bytes with junk
    // above bit 31 in the last byte, which the block must drop.
    task automatic send_length(input logic [LEN_W-1:0] len);
        int unsigned m;
        int unsigned n;
        int unsigned r;
        bit          wrap;
        logic [7:0]  b;
        m = 1;
        while (m < MAX_LENGTH_BYTES_DEF && (len >> (7 * m)) != 0) m++;
        r    = $urandom_range(0, 9);
        wrap = 1'b0;
        if (r < 7) begin
            n = m;
        end else if (r < 9) begin
            n = $urandom_range(m, MAX_LENGTH_BYTES_DEF);
        end else begin
            n    = MAX_LENGTH_BYTES_DEF;
            wrap = 1'b1;
        end
        for (int unsigned i = 0; i < n; i++) begin
            b = {1'b0, 7'(len >> (7 * i))};
            if (wrap && i == MAX_LENGTH_BYTES_DEF - 1) b[6:4] = 3'($urandom_range(1, 7));
            if (i < n - 1) b[7] = 1'b1;
            send_byte(b);
        end
    endtask

    // Five continuation bytes in a row: the block reports a length error
    // and starts over at a new packet.
    task automatic send_overlong();
        repeat (MAX_LENGTH_BYTES_DEF) send_byte(8'h80 | 8'($urandom_range(0, 127)));
    endtask

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) return 0;
        if (r < 80) return $urandom_range(1, 8);
        if (r < 97) return $urandom_range(9, 40);
        return $urandom_range(100, 300);
    endfunction

    // A packet with random content; with may_break set, either length may
    // be replaced by an overlong one, which ends the packet there.
    task automatic send_packet(input int unsigned name_len, input int unsigned pay_len,
                               input bit may_break);
        if (may_break && $urandom_range(0, 19) == 0) begin
            send_overlong();
            return;
        end
        send_length(name_len);
        repeat (name_len) send_byte(8'($urandom));
        if (may_break && $urandom_range(0, 19) == 0) begin
            send_overlong();
            return;
        end
        send_length(pay_len);
        repeat (pay_len) send_byte(8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Output side: check every accepted beat, then draw how long to stall
    // before taking the next one.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
                tracker.match_beat(o_out_kind, o_out_data, o_field_length, o_packet_last);
                hold = rx_idle ? $urandom_range(0, 6) : 0;
            end
            if (long_hold_req != 0) begin
                hold          = long_hold_req;
                long_hold_req = 0;
            end
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                hold--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] directed[] = '{
            // empty name, then empty payload: end marker only
            8'h00, 8'h00,
            // one name byte, two payload bytes, data extremes
            8'h01, 8'hFF, 8'h02, 8'h00, 8'h80,
            // name length of five bytes whose top bit lands past bit 31,
            // so it wraps to one; then an overlong payload length
            8'h81, 8'h80, 8'h80, 8'h80, 8'h10, 8'h55,
            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            // name length that wraps to zero, then an empty payload
            8'h80, 8'h80, 8'h80, 8'h80, 8'h70, 8'h00
        };
        bit held;
        bit drained;
        held    = 1'b0;
        drained = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_byte(directed[k]);

        while (n_sent < directed.size() + 1600) begin
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;

            if (!held && n_sent >= 600) begin
                // Receiver holds off while the sender streams name and
                // payload bytes back to back: both registers fill and the
                // input stall must rise and hold the stream.
                held          = 1'b1;
                long_hold_req = 250;
                tx_idle       = 1'b0;
                send_packet(30, 20, 1'b0);
            end else if (!drained && n_sent >= 1100) begin
                // Sender goes quiet until every predicted beat is out.
                drained    = 1'b1;
                i_in_valid <= 1'b0;
                do begin
                    @(posedge i_clk);
                end while (tracker.pending_beats.size() != 0);
                send_packet(pick_len(), pick_len(), 1'b1);
            end else begin
                send_packet(pick_len(), pick_len(), 1'b1);
            end
        end
        i_in_valid <= 1'b0;

        while (tracker.pending_beats.size() != 0) @(posedge i_clk);
        // trailing length bytes make no beat; give the pipeline time to show
        // anything spurious
        repeat (8) @(posedge i_clk);

        $display("covered %0d stream bytes and %0d result beats: %0d name, %0d payload,",
                 tracker.n_bytes, tracker.n_beats, tracker.n_kind[KIND_NAME],
                 tracker.n_kind[KIND_PAYLOAD]);
        $display("%0d empty-payload ends, %0d length errors, with a long output hold and a drain",
                 tracker.n_kind[KIND_EMPTY_END], tracker.n_kind[KIND_ERROR]);
        if (tracker.n_fail == 0 && tracker.pending_beats.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #400_000;
        $error("timeout with %0d beats still predicted", tracker.pending_beats.size());
        $display("status: fail");
        $finish;
    end

endmodule
